/* hw/rtl/pqpp_pkg.sv */
// ----------------------------------------------------------------------------
// pqpp_pkg
// Shared types, constants and helpers for the palette quantizer / packer.
// ----------------------------------------------------------------------------
package pqpp_pkg;

  // Default palette store depth
  localparam int PALETTE_DEPTH_DEF = 256;

  // Fixed field widths
  localparam int COMP_W   = 8;   // one color component
  localparam int ENTRY_W  = 24;  // packed RGB palette entry
  localparam int DIST_W   = 18;  // sum of three 16-bit squares
  localparam int COUNT_W  = 9;   // palette_count register
  localparam int DEPTH_W  = 2;   // depth_code register
  localparam int BYTE_W   = 8;
  localparam int GATHER_W = 3;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_DEPTH_CODE    = 1'b0;
  localparam logic REG_PALETTE_COUNT = 1'b1;

  // Reset values
  localparam logic [DEPTH_W-1:0] DEPTH_CODE_RST    = 2'd3;
  localparam logic [COUNT_W-1:0] PALETTE_COUNT_RST = 9'd256;

  // Input item kinds (carried on tuser)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Depth codes
  localparam logic [DEPTH_W-1:0] DC_1BPP = 2'd0;
  localparam logic [DEPTH_W-1:0] DC_2BPP = 2'd1;
  localparam logic [DEPTH_W-1:0] DC_4BPP = 2'd2;
  localparam logic [DEPTH_W-1:0] DC_8BPP = 2'd3;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DEPTH_W-1:0] depth_code;
    logic [COUNT_W-1:0] palette_count;
    logic               depth_wr;      // pulse: depth_code written
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // write palette entry from input beat
    logic start;   // capture pixel, reset search
    logic search;  // walk palette entries
    logic pack;    // merge chosen index into pack register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic search_done;  // all entries compared
    logic byte_done;    // next pack completes a byte
    logic out_free;     // output register can take a byte
  } status_t;

  // Index mask for the current bits per pixel
  function automatic logic [BYTE_W-1:0] depth_mask(input logic [DEPTH_W-1:0] dc);
    logic [BYTE_W-1:0] m;
    unique case (dc)
      DC_1BPP: m = 8'h01;
      DC_2BPP: m = 8'h03;
      DC_4BPP: m = 8'h0F;
      DC_8BPP: m = 8'hFF;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // Bit position of the pixel in the byte, first pixel in the top bits
  function automatic logic [GATHER_W-1:0] pack_shift(input logic [DEPTH_W-1:0]  dc,
                                                     input logic [GATHER_W-1:0] g);
    logic [GATHER_W-1:0] s;
    unique case (dc)
      DC_1BPP: s = 3'd7 - g;
      DC_2BPP: s = {~g[1:0], 1'b0};
      DC_4BPP: s = {~g[0], 2'b00};
      DC_8BPP: s = 3'd0;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Pixels per byte, modulo 8 (eight pixels wrap to zero)
  function automatic logic [GATHER_W-1:0] per_byte(input logic [DEPTH_W-1:0] dc);
    logic [GATHER_W-1:0] n;
    unique case (dc)
      DC_1BPP: n = 3'd0;
      DC_2BPP: n = 3'd4;
      DC_4BPP: n = 3'd2;
      DC_8BPP: n = 3'd1;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/palette_quantize_pixel_pack.sv */
// ----------------------------------------------------------------------------
// palette_quantize_pixel_pack
// Nearest-palette-color quantizer with MSB-first bit packing.
// ----------------------------------------------------------------------------
// Load beats (tuser = 0) write one RGB entry into the palette RAM. Pixel
// beats (tuser = 1) scan entries 0 .. palette_count-1 (palette_count
// saturated to PALETTE_DEPTH) through a single squared-distance unit fed by
// the palette RAM read port, one entry per cycle. A pixel passes the accept,
// one read per entry, a drain of the RAM-read and square stages, the check
// for the search end and the pack step before the next beat is accepted; a
// count of zero skips the reads and the drain. Ties keep
// the lowest index. The chosen index, masked to 1, 2, 4 or 8 bits per pixel,
// is packed first-pixel-in-the-top-bits; a byte leaves on m_tdata once 8/bpp
// pixels are gathered and waits in an output register, so a new beat is
// taken while it is pending; the pack step stalls only if the next byte is
// done while that register is still full. Writing depth_code drops a partly
// filled byte. Read an entry only after it was loaded; unloaded entries give
// undefined results. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module palette_quantize_pixel_pack #(
  parameter int PALETTE_DEPTH = pqpp_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // entry_index, red, green, blue
  input  logic                             s_tuser,   // opcode
  // output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pqpp_pkg::BYTE_W-1:0]      m_tdata,   // packed_byte
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pqpp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqpp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqpp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  pqpp_pkg::cfg_t    cfg;
  pqpp_pkg::cmd_t    cmd;
  pqpp_pkg::status_t status;

  pqpp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pqpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pqpp_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

/* hw/rtl/pqpp_ram.sv */
// ----------------------------------------------------------------------------
// pqpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqpp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pqpp_regs.sv */
// ----------------------------------------------------------------------------
// pqpp_regs
// APB register file: depth_code and palette_count.
// ----------------------------------------------------------------------------
module pqpp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pqpp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqpp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqpp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output pqpp_pkg::cfg_t                   cfg
);

  logic                            wr_en;
  logic                            reg_sel;
  logic [pqpp_pkg::DEPTH_W-1:0]    depth_code;
  logic [pqpp_pkg::COUNT_W-1:0]    palette_count;
  logic                            depth_wr;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  // registers sit on a 4-byte stride
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code    <= pqpp_pkg::DEPTH_CODE_RST;
      palette_count <= pqpp_pkg::PALETTE_COUNT_RST;
      depth_wr      <= 1'b0;
    end else begin
      depth_wr <= 1'b0;
      if (wr_en) begin
        unique case (reg_sel)
          pqpp_pkg::REG_DEPTH_CODE: begin
            depth_code <= pwdata[pqpp_pkg::DEPTH_W-1:0];
            depth_wr   <= 1'b1;
          end
          pqpp_pkg::REG_PALETTE_COUNT: begin
            palette_count <= pwdata[pqpp_pkg::COUNT_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      pqpp_pkg::REG_DEPTH_CODE:
        prdata = pqpp_pkg::APB_DATA_W'(depth_code);
      pqpp_pkg::REG_PALETTE_COUNT:
        prdata = pqpp_pkg::APB_DATA_W'(palette_count);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.depth_code    = depth_code;
  assign cfg.palette_count = palette_count;
  assign cfg.depth_wr      = depth_wr;

endmodule

/* hw/rtl/pqpp_ctrl.sv */
// ----------------------------------------------------------------------------
// pqpp_ctrl
// Sequencer: takes beats, runs the palette search, then packs the result.
// ----------------------------------------------------------------------------
module pqpp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              opcode,
  output logic              s_tready,
  output pqpp_pkg::cmd_t    cmd,
  input  pqpp_pkg::status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_PACK   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   beat;

  assign s_tready = (state == ST_IDLE);
  assign beat     = s_tvalid & s_tready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (beat) begin
          if (opcode == pqpp_pkg::OP_PIXEL) begin
            cmd.start  = 1'b1;
            state_next = ST_SEARCH;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_done) begin
          state_next = ST_PACK;
        end
      end
      ST_PACK: begin
        // hold while a finished byte cannot enter the output register
        if (!status.byte_done || status.out_free) begin
          cmd.pack   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/pqpp_dp.sv */
// ----------------------------------------------------------------------------
// pqpp_dp
// Datapath: palette store, distance pipeline, best-match tracking,
// bit packer and output register.
// ----------------------------------------------------------------------------
module pqpp_dp #(
  parameter int PALETTE_DEPTH = pqpp_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pqpp_pkg::cfg_t                cfg,
  input  pqpp_pkg::cmd_t                cmd,
  output pqpp_pkg::status_t             status,
  input  logic [31:0]                   s_tdata,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [pqpp_pkg::BYTE_W-1:0]   m_tdata
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [pqpp_pkg::COUNT_W-1:0] DEPTH_LIM = pqpp_pkg::COUNT_W'(PALETTE_DEPTH);
  localparam logic [pqpp_pkg::DIST_W-1:0]  DIST_MAX  = '1;

  // input beat fields
  logic [7:0]                    in_index;
  logic [pqpp_pkg::ENTRY_W-1:0]  in_rgb;

  // pixel under search
  logic [pqpp_pkg::COMP_W-1:0]   pix_r, pix_g, pix_b;

  // search control
  logic [CW-1:0]                 limit;
  logic [CW-1:0]                 cnt;
  logic                          issue;
  logic                          we;

  // pipeline
  logic [pqpp_pkg::ENTRY_W-1:0]  rdata;
  logic                          v1, v2;
  logic [IW-1:0]                 idx1, idx2;
  logic [pqpp_pkg::COMP_W-1:0]   ad_r, ad_g, ad_b;
  logic [15:0]                   sq_r, sq_g, sq_b;
  logic [pqpp_pkg::DIST_W-1:0]   sq_sum;
  logic [pqpp_pkg::DIST_W-1:0]   best_dist;
  logic [IW-1:0]                 best_idx;

  // packer
  logic [pqpp_pkg::BYTE_W-1:0]   pack_reg;
  logic [pqpp_pkg::GATHER_W-1:0] gathered;
  logic [pqpp_pkg::GATHER_W-1:0] gathered_next;
  logic [pqpp_pkg::BYTE_W-1:0]   colour;
  logic [pqpp_pkg::BYTE_W-1:0]   pack_next;
  logic                          byte_done;
  logic                          out_valid;
  logic [pqpp_pkg::BYTE_W-1:0]   out_data;

  assign in_index = s_tdata[7:0];
  assign in_rgb   = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

  // entries outside the store are dropped
  assign we = cmd.load & (9'(in_index) < DEPTH_LIM);

  // searched entries: palette_count saturated to the store depth
  assign limit = (cfg.palette_count > DEPTH_LIM) ? CW'(PALETTE_DEPTH)
                                                 : CW'(cfg.palette_count);
  assign issue = cmd.search & (cnt < limit);

  pqpp_ram #(
    .WIDTH (pqpp_pkg::ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (we),
    .waddr (in_index[IW-1:0]),
    .wdata (in_rgb),
    .re    (issue),
    .raddr (cnt[IW-1:0]),
    .rdata (rdata)
  );

  // pixel capture and entry counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_r <= in_rgb[23:16];
      pix_g <= in_rgb[15:8];
      pix_b <= in_rgb[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + CW'(1);
    end
  end

  // absolute component differences against the read entry
  always_comb begin
    ad_r = (pix_r >= rdata[23:16]) ? pix_r - rdata[23:16] : rdata[23:16] - pix_r;
    ad_g = (pix_g >= rdata[15:8])  ? pix_g - rdata[15:8]  : rdata[15:8]  - pix_g;
    ad_b = (pix_b >= rdata[7:0])   ? pix_b - rdata[7:0]   : rdata[7:0]   - pix_b;
  end

  // valid / index tags along the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // stage: squares
  always_ff @(posedge clk) begin
    idx1 <= cnt[IW-1:0];
    idx2 <= idx1;
    sq_r <= ad_r * ad_r;
    sq_g <= ad_g * ad_g;
    sq_b <= ad_b * ad_b;
  end

  assign sq_sum = pqpp_pkg::DIST_W'(sq_r) + pqpp_pkg::DIST_W'(sq_g)
                + pqpp_pkg::DIST_W'(sq_b);

  // stage: sum and compare; strict less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_dist <= DIST_MAX;
      best_idx  <= '0;
    end else if (v2 && (sq_sum < best_dist)) begin
      best_dist <= sq_sum;
      best_idx  <= idx2;
    end
  end

  // packer
  always_comb begin
    colour        = pqpp_pkg::BYTE_W'(best_idx) & pqpp_pkg::depth_mask(cfg.depth_code);
    pack_next     = pack_reg | (colour << pqpp_pkg::pack_shift(cfg.depth_code, gathered));
    gathered_next = gathered + 3'd1;
    byte_done     = (gathered_next == pqpp_pkg::per_byte(cfg.depth_code));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.depth_wr) begin
      pack_reg <= '0;
      gathered <= '0;
    end else if (cmd.pack) begin
      if (byte_done) begin
        pack_reg <= '0;
        gathered <= '0;
      end else begin
        pack_reg <= pack_next;
        gathered <= gathered_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pack && byte_done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack && byte_done) begin
      out_data <= pack_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign status.search_done = (cnt >= limit) & ~v1 & ~v2 & ~cmd.start;
  assign status.byte_done   = byte_done;
  assign status.out_free    = ~out_valid | m_tready;

endmodule

/* test/palette_quantize_pixel_pack_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_quantize_pixel_pack_test
// Self-checking bench for the palette quantizer and pixel packer.
// ----------------------------------------------------------------------------
// Loads a full palette, then runs directed checks on nearest-color search,
// ties, index masking, packing order, depth changes and the count limits,
// followed by random phases across all depths and several counts. A mirror of the
// palette and pack state predicts every packed byte; bytes leaving on
// m_tdata are compared in order. Both stream sides idle at random, and one
// stretch holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module palette_quantize_pixel_pack_test;
  import pqpp_pkg::*;

  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int DRAIN_CYCLES = PALETTE_DEPTH_DEF + 40;
  localparam int SINK_HOLD    = 1500;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 70;

  logic clk = 1'b0;
  logic rst;

  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // entry_index, red, green, blue
  logic                  s_tuser;   // opcode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [BYTE_W-1:0]     m_tdata;   // packed_byte
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  palette_quantize_pixel_pack dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Mirror of the block state
  logic [ENTRY_W-1:0] palette_mirror [PALETTE_DEPTH_DEF];
  logic [DEPTH_W-1:0] depth_now = DEPTH_CODE_RST;
  logic [COUNT_W-1:0] count_now = PALETTE_COUNT_RST;
  logic [BYTE_W-1:0]  pack_acc  = '0;
  int                 gathered  = 0;

  logic [BYTE_W-1:0]  packed_bytes_due [$];
  logic [BYTE_W-1:0]  byte_want;
  int                 error_count = 0;
  int                 cycle_count = 0;

  bit src_gaps_on   = 1'b1;
  bit sink_gaps_on  = 1'b1;
  bit sink_hold_req = 1'b0;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("palette_quantize_pixel_pack verification failed");
      $finish;
    end
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(input int long_max);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, long_max);
  endfunction

  // Nearest entry search, then pack the masked index into the byte
  function automatic void quantize_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int limit, best, best_dist, sq_sum, dr, dg, db, bpp, pix_per_byte, shift;
    logic [BYTE_W-1:0] index_bits;
    limit = (count_now > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : int'(count_now);
    best = 0;
    best_dist = 32'h7fff_ffff;
    for (int i = 0; i < limit; i++) begin
      dr = int'(r) - int'(palette_mirror[i][23:16]);
      dg = int'(g) - int'(palette_mirror[i][15:8]);
      db = int'(b) - int'(palette_mirror[i][7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best = i;
      end
    end
    bpp = 1 << depth_now;
    pix_per_byte = 8 >> depth_now;
    index_bits = BYTE_W'(best & ((1 << bpp) - 1));
    shift = bpp * (pix_per_byte - 1 - gathered);
    pack_acc = pack_acc | BYTE_W'(index_bits << shift);
    gathered++;
    if (gathered == pix_per_byte) begin
      packed_bytes_due = {packed_bytes_due, pack_acc};
      pack_acc = '0;
      gathered = 0;
    end
  endfunction

  // Send one beat, then update the mirror once it is taken
  task automatic send_item(input logic op, input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = src_gaps_on ? pick_gap(400) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {b, g, r, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_LOAD) palette_mirror[idx] = {r, g, b};
    else quantize_pixel(r, g, b);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(OP_PIXEL, 8'($urandom), r, g, b);
  endtask

  // Drain: all bytes in, then let a pixel still in the search finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (packed_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then idle
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_depth(input logic [DEPTH_W-1:0] code);
    apb_write({REG_DEPTH_CODE, 2'b00}, 32'(code));
    depth_now = code;
    pack_acc  = '0;
    gathered  = 0;
  endtask

  task automatic configure_count(input logic [COUNT_W-1:0] count);
    apb_write({REG_PALETTE_COUNT, 2'b00}, 32'(count));
    count_now = count;
  endtask

  // Output side: random stalls, plus one long hold on request
  initial begin : byte_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        hold_left = SINK_HOLD;
        sink_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(300);
        m_tready <= (stall_left == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output beat with the oldest predicted byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (packed_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %02h", $time, m_tdata);
        error_count++;
      end else begin
        byte_want = packed_bytes_due.pop_front();
        if (m_tdata !== byte_want) begin
          $display("%0t: packed_byte mismatch, expected %02h, actual %02h",
                   $time, byte_want, m_tdata);
          error_count++;
        end
      end
    end
  end

  // Every entry gets a color before any search can read it
  task automatic test_palette_fill();
    for (int i = 0; i < PALETTE_DEPTH_DEF; i++)
      send_item(OP_LOAD, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Exact hits, extremes and ties at 8 bpp over six entries
  task automatic test_nearest_directed();
    send_item(OP_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd1, 8'hff, 8'hff, 8'hff);
    send_item(OP_LOAD, 8'd2, 8'hff, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd3, 8'h00, 8'hff, 8'h80);
    send_item(OP_LOAD, 8'd4, 8'h00, 8'hff, 8'h80);
    send_item(OP_LOAD, 8'd5, 8'h80, 8'h80, 8'h80);
    settle();
    configure_depth(DC_8BPP);
    configure_count(9'd6);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hfa, 8'h05, 8'h05);
    send_pixel(8'h00, 8'hff, 8'h80);  // duplicate entries, lower wins
    send_pixel(8'h40, 8'h40, 8'h40);  // equal distance to black and gray
  endtask

  // 1 bpp packing with masked indices, a discarded partial byte, then 2 bpp packing
  task automatic test_packing_directed();
    settle();
    configure_depth(DC_1BPP);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hf0, 8'h10, 8'h00);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'hf0, 8'h80);
    send_pixel(8'h7f, 8'h80, 8'h81);
    send_pixel(8'hfe, 8'hfe, 8'hfe);
    settle();
    configure_depth(DC_4BPP);
    send_pixel(8'h80, 8'h80, 8'h80);
    settle();
    configure_depth(DC_2BPP);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h00, 8'hff, 8'h80);
    send_pixel(8'hff, 8'h00, 8'h00);
  endtask

  // No entry searched, and a count beyond the store
  task automatic test_count_limits();
    settle();
    configure_depth(DC_8BPP);
    configure_count(9'd0);
    send_pixel(8'hff, 8'hff, 8'hff);
    settle();
    configure_count(9'd511);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Random phases over depths and counts, mostly small searches
  task automatic test_random_phases();
    logic [DEPTH_W-1:0] depth_seq [4];
    int count_seq [PHASES];
    logic [ENTRY_W-1:0] near;
    logic [7:0] idx;
    depth_seq = '{DC_1BPP, DC_8BPP, DC_2BPP, DC_4BPP};
    count_seq = '{1, 256, 2, 16, 0, 7, 511, 4, 255, 3, 12, 8};
    for (int p = 0; p < PHASES; p++) begin
      settle();
      src_gaps_on  = (p % 3 != 2);
      sink_gaps_on = (p % 3 != 2);
      configure_count(COUNT_W'(count_seq[p]));
      configure_depth(p < 4 ? depth_seq[p] : DEPTH_W'($urandom_range(0, 3)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
          send_item(OP_LOAD, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if ($urandom_range(0, 1) == 0) begin
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          // near a low entry so small counts see close calls and ties
          near = palette_mirror[$urandom_range(0, 15)];
          send_pixel(near[23:16] ^ 8'($urandom_range(0, 3)),
                     near[15:8] ^ 8'($urandom_range(0, 3)),
                     near[7:0] ^ 8'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  // Output held off for a long stretch while pixels keep coming
  task automatic test_output_backpressure();
    settle();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b1;
    configure_count(9'd4);
    configure_depth(DC_8BPP);
    sink_hold_req = 1'b1;
    for (int n = 0; n < 40; n++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    src_gaps_on = 1'b1;
  endtask

  initial begin
    s_tvalid <= 1'b0;
    s_tuser  <= OP_LOAD;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst      <= 1'b1;
    repeat (4) @(posedge clk);
    rst      <= 1'b0;
    @(posedge clk);

    test_palette_fill();
    test_nearest_directed();
    test_packing_directed();
    test_count_limits();
    test_random_phases();
    test_output_backpressure();
    settle();

    if (packed_bytes_due.size() != 0) begin
      $display("%0t: %0d packed bytes never arrived", $time, packed_bytes_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("palette_quantize_pixel_pack verification clean");
    end else begin
      $display("palette_quantize_pixel_pack verification failed");
    end
    $finish;
  end

endmodule
